FILE: design/lis_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lis_pkg
// Shared types and the data width for the list insertion sorter: the command and
// status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package lis_pkg;

  localparam int unsigned DATA_W = 32;

  // controller -> datapath
  typedef struct packed {
    logic insert;  // place value_i into the sorted chain, or drop it when full
    logic pop;     // move the head entry into the output register, shift down
  } lis_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_entry;  // exactly one entry left in the chain
  } lis_status_t;

endpackage : lis_pkg
`default_nettype wire

FILE: design/list_insertion_sorter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// list_insertion_sorter
// Sorts a list of signed 32-bit values and emits it in ascending order.
// ----------------------------------------------------------------------------
// Values arrive one per input transaction; a transaction with last_i set
// closes the list. While a list is collected the block takes one value every
// cycle: all MAX_ITEMS entries of the insertion chain compare against the new
// value in parallel and the larger ones shift up one place in the same cycle,
// so a value lands ahead of the first stored value that is not smaller.
// Values that arrive with the chain already full are dropped and every
// result of that list then carries overflow_o. After the closing
// transaction the chain drains from its low end, one result per cycle while
// the output side keeps up, with end_of_list_o on the largest value. Input
// ready is low during that drain, so every value of a list, dropped ones
// included, is taken in before its first result is emitted; the next list
// is accepted as soon as the last result has moved into the output register,
// even while it waits there.
// ----------------------------------------------------------------------------
module list_insertion_sorter
  import lis_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // input channel
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic signed [DATA_W-1:0] value_i,
  input  wire logic                     last_i,
  // result channel
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic signed [DATA_W-1:0]      sorted_value_o,
  output logic                          end_of_list_o,
  output logic                          overflow_o
);

  lis_cmd_t    cmd;     // insert / pop strobes from the sequencer
  lis_status_t status;  // chain state back to the sequencer

  // Sequencer: collect phase, then drain phase, plus output valid register.
  lis_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // Insertion chain, fill count, drop flag and output payload.
  lis_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .value_i        (value_i),
    .sorted_value_o (sorted_value_o),
    .end_of_list_o  (end_of_list_o),
    .overflow_o     (overflow_o)
  );

endmodule : list_insertion_sorter
`default_nettype wire

FILE: design/lis_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lis_datapath
// Systolic insertion chain of MAX_ITEMS entries, fill count, drop flag and
// the output payload register.
// ----------------------------------------------------------------------------
module lis_datapath
  import lis_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire lis_cmd_t                 cmd_i,
  output lis_status_t                   status_o,
  input  wire logic signed [DATA_W-1:0] value_i,
  output logic signed [DATA_W-1:0]      sorted_value_o,
  output logic                          end_of_list_o,
  output logic                          overflow_o
);

  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

  logic signed [DATA_W-1:0] store_q [MAX_ITEMS];
  logic signed [DATA_W-1:0] store_d [MAX_ITEMS];
  logic [MAX_ITEMS-1:0]     lt;
  logic [CNT_W-1:0]         count_q, count_d;
  logic                     dropped_q, dropped_d;
  logic                     full;
  logic                     do_insert;

  assign full      = (count_q == CNT_W'(MAX_ITEMS));
  assign do_insert = cmd_i.insert && !full;

  // Entry i holds a value smaller than the new one; a prefix, since sorted.
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cmp
    assign lt[i] = (CNT_W'(i) < count_q) && (store_q[i] < value_i);
  end

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_entry
    logic prev_lt;
    logic signed [DATA_W-1:0] below;
    logic signed [DATA_W-1:0] above;
    if (i == 0) begin : g_first
      assign prev_lt = 1'b1;
      assign below   = value_i;
    end else begin : g_rest
      assign prev_lt = lt[i-1];
      assign below   = store_q[i-1];
    end
    if (i == MAX_ITEMS - 1) begin : g_top
      assign above = store_q[i];
    end else begin : g_mid
      assign above = store_q[i+1];
    end

    always_comb begin
      store_d[i] = store_q[i];
      if (do_insert) begin
        if (lt[i]) begin
          store_d[i] = store_q[i];
        end else if (prev_lt) begin
          store_d[i] = value_i;
        end else begin
          store_d[i] = below;
        end
      end else if (cmd_i.pop) begin
        store_d[i] = above;
      end
    end
  end

  always_comb begin
    count_d   = count_q;
    dropped_d = dropped_q;
    if (cmd_i.insert) begin
      if (full) begin
        dropped_d = 1'b1;
      end else begin
        count_d = count_q + CNT_W'(1);
      end
    end else if (cmd_i.pop) begin
      count_d = count_q - CNT_W'(1);
      if (status_o.last_entry) begin
        dropped_d = 1'b0;
      end
    end
  end

  assign status_o.last_entry = (count_q == CNT_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      dropped_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      dropped_q <= dropped_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_ITEMS; i++) begin
      store_q[i] <= store_d[i];
    end
    if (cmd_i.pop) begin
      sorted_value_o <= store_q[0];
      end_of_list_o  <= status_o.last_entry;
      overflow_o     <= dropped_q;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_ITEMS))
    else $error("fill count beyond capacity");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> count_q != '0)
    else $error("pop from an empty chain");
  a_drop_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.insert && full) |=> dropped_q && $stable(count_q))
    else $error("insert into a full chain not flagged as dropped");
`endif

endmodule : lis_datapath
`default_nettype wire

FILE: design/lis_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lis_ctrl
// Collect/emit sequencer and output valid register for the sorter.
// ----------------------------------------------------------------------------
module lis_ctrl
  import lis_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        last_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output lis_cmd_t         cmd_o,
  input  wire lis_status_t status_i
);

  typedef enum logic {
    ST_COLLECT,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign in_ready_o  = (state_q == ST_COLLECT);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  assign cmd_o.insert = in_valid_i && in_ready_o;
  assign cmd_o.pop    = (state_q == ST_EMIT) && out_free;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.pop) begin
      out_valid_d = 1'b1;
    end
    case (state_q)
      ST_COLLECT: begin
        if (cmd_o.insert && last_i) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (cmd_o.pop && status_i.last_entry) begin
          state_d = ST_COLLECT;
        end
      end
      default: state_d = ST_COLLECT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_COLLECT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule : lis_ctrl
`default_nettype wire
